### src/gradient_norm_statistics_macros.svh
// assertion macros shared by the rtl
`ifndef GRADIENT_NORM_STATISTICS_MACROS_SVH
`define GRADIENT_NORM_STATISTICS_MACROS_SVH

// property that must hold at every edge out of reset
`define GNS_ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("gns check failed");

// implication checked in the cycle after the condition
`define GNS_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("gns check failed");

`endif

### src/gns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gns_pkg;
  localparam int unsigned MaxElements = 65536;
  localparam int unsigned ValueBits = 16;

  localparam logic [1:0] ACT_GRAD = 2'd0;
  localparam logic [1:0] ACT_WEIGHT = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;

  // datapath operation codes
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_SQRT  = 3'd1,
    OP_DIV   = 3'd2
  } op_t;

  // sqrt / divide operand selection
  typedef enum logic [2:0] {
    SEL_GNORM = 3'd0,
    SEL_WNORM = 3'd1,
    SEL_VAR   = 3'd2,
    SEL_GLOB  = 3'd3,
    SEL_MEAN  = 3'd4,
    SEL_DEV   = 3'd5,
    SEL_RATIO = 3'd6
  } sel_t;

  typedef struct packed {
    logic accept;
    logic flush;
    logic start_op;
    op_t  op;
    sel_t sel;
    logic emit_layer;
    logic emit_flush;
  } cmd_t;

  typedef struct packed {
    logic op_done;
    logic have_grad;
    logic wnorm_zero;
  } stat_t;
endpackage
`default_nettype wire

### src/gradient_norm_statistics.sv
`timescale 1ns / 1ps
`default_nettype none
// gradient norm statistics: one input beat is taken per cycle while busy is low; gradient
// and plain weight beats leave busy low. the weight beat marked last raises busy for
// the layer summary: three 64-bit square roots (load, 32 steps of two bits, finish and
// hand-over) and three 64-bit divides in the bit-serial divider, then the output state;
// an empty gradient skips the variance root and both divides by count, and a zero weight
// norm skips the ratio divide. a flush beat holds busy for one root and the output state.
// each result appears for exactly one cycle with strobe high, the cycle after the output
// state as busy falls; the receiver cannot stall, so it must take every strobed beat.
module gradient_norm_statistics #(
  parameter int unsigned MAX_ELEMENTS = gns_pkg::MaxElements,
  parameter int unsigned VALUE_BITS = gns_pkg::ValueBits
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   action,
  input  wire logic signed [VALUE_BITS-1:0] value,
  input  wire logic                         last,
  input  wire logic [15:0]                  layer_index,
  output logic                              strobe,
  output logic                              kind,
  output logic [15:0]                       layer_tag,
  output logic [16:0]                       count,
  output logic signed [15:0]                mean,
  output logic [15:0]                       deviation,
  output logic signed [15:0]                minimum,
  output logic signed [15:0]                maximum,
  output logic [31:0]                       grad_norm,
  output logic [23:0]                       weight_norm,
  output logic [31:0]                       ratio
);
  gns_pkg::cmd_t  cmd;
  gns_pkg::stat_t stat;

  // sequencer
  gns_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .action(action), .last(last),
    .stat(stat), .busy(busy), .cmd(cmd)
  );

  // accumulators, root unit and divider
  gns_dp #(.MAX_ELEMENTS(MAX_ELEMENTS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .action(action), .value(value),
    .layer_index(layer_index), .stat(stat), .strobe(strobe), .kind(kind),
    .layer_tag(layer_tag), .count(count), .mean(mean), .deviation(deviation),
    .minimum(minimum), .maximum(maximum), .grad_norm(grad_norm),
    .weight_norm(weight_norm), .ratio(ratio)
  );
endmodule
`default_nettype wire

### src/gns_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "gradient_norm_statistics_macros.svh"
module gns_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [1:0]      action,
  input  wire logic            last,
  input  wire gns_pkg::stat_t  stat,
  output logic                 busy,
  output gns_pkg::cmd_t        cmd
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_GN    = 10'b0000000010,
    S_WN    = 10'b0000000100,
    S_VAR   = 10'b0000001000,
    S_MEAN  = 10'b0000010000,
    S_DEV   = 10'b0000100000,
    S_RATIO = 10'b0001000000,
    S_OUT   = 10'b0010000000,
    S_GLOB  = 10'b0100000000,
    S_FOUT  = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   issued, issued_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    issued_next = issued;
    cmd = '0;
    cmd.op = gns_pkg::OP_NONE;
    cmd.sel = gns_pkg::SEL_GNORM;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (action == gns_pkg::ACT_FLUSH) state_next = S_GLOB;
          else if (action == gns_pkg::ACT_WEIGHT && last) state_next = S_GN;
          issued_next = 1'b0;
        end
      end
      S_OUT: begin
        cmd.emit_layer = 1'b1;
        state_next = S_IDLE;
      end
      S_FOUT: begin
        cmd.emit_flush = 1'b1;
        cmd.flush = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        priority case (state)
          S_GN:    begin cmd.op = gns_pkg::OP_SQRT; cmd.sel = gns_pkg::SEL_GNORM; end
          S_WN:    begin cmd.op = gns_pkg::OP_SQRT; cmd.sel = gns_pkg::SEL_WNORM; end
          S_VAR:   begin cmd.op = gns_pkg::OP_SQRT; cmd.sel = gns_pkg::SEL_VAR; end
          S_MEAN:  begin cmd.op = gns_pkg::OP_DIV;  cmd.sel = gns_pkg::SEL_MEAN; end
          S_DEV:   begin cmd.op = gns_pkg::OP_DIV;  cmd.sel = gns_pkg::SEL_DEV; end
          S_RATIO: begin cmd.op = gns_pkg::OP_DIV;  cmd.sel = gns_pkg::SEL_RATIO; end
          default: begin cmd.op = gns_pkg::OP_SQRT; cmd.sel = gns_pkg::SEL_GLOB; end
        endcase
        // skip work whose answer is forced to zero
        if (!issued && ((state == S_VAR || state == S_MEAN || state == S_DEV) &&
            !stat.have_grad || state == S_RATIO && stat.wnorm_zero)) begin
          cmd.op = gns_pkg::OP_NONE;
        end
        if (cmd.op == gns_pkg::OP_NONE || (issued && stat.op_done)) begin
          issued_next = 1'b0;
          priority case (state)
            S_GN:    state_next = S_WN;
            S_WN:    state_next = S_VAR;
            S_VAR:   state_next = S_MEAN;
            S_MEAN:  state_next = S_DEV;
            S_DEV:   state_next = S_RATIO;
            S_RATIO: state_next = S_OUT;
            default: state_next = S_FOUT;
          endcase
        end else if (!issued) begin
          cmd.start_op = 1'b1;
          issued_next = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  `GNS_ASSERT_ALWAYS(a_onehot, clk, rst, $onehot(state))
  `GNS_ASSERT_ALWAYS(a_no_accept_busy, clk, rst, !(cmd.accept && busy))
  `GNS_ASSERT_NEXT(a_out_idle, clk, rst, cmd.emit_layer || cmd.emit_flush, state == S_IDLE)
endmodule
`default_nettype wire

### src/gns_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "gradient_norm_statistics_macros.svh"
module gns_dp #(
  parameter int unsigned MAX_ELEMENTS = gns_pkg::MaxElements,
  parameter int unsigned VALUE_BITS = gns_pkg::ValueBits
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire gns_pkg::cmd_t                cmd,
  input  wire logic [1:0]                   action,
  input  wire logic signed [VALUE_BITS-1:0] value,
  input  wire logic [15:0]                  layer_index,
  output gns_pkg::stat_t                    stat,
  output logic                              strobe,
  output logic                              kind,
  output logic [15:0]                       layer_tag,
  output logic [16:0]                       count,
  output logic signed [15:0]                mean,
  output logic [15:0]                       deviation,
  output logic signed [15:0]                minimum,
  output logic signed [15:0]                maximum,
  output logic [31:0]                       grad_norm,
  output logic [23:0]                       weight_norm,
  output logic [31:0]                       ratio
);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int SQ = 2 * VALUE_BITS - 1;
  localparam int SW = SQ + CW;              // square sum width
  localparam int GW = VALUE_BITS + CW;      // signed sum width
  localparam logic [SW-1:0] WSQ_LIMIT = SW'(MAX_ELEMENTS) << (2 * VALUE_BITS - 2);
  localparam logic [CW-1:0] MAXN = CW'(MAX_ELEMENTS);

  logic signed [GW-1:0]     gsum;
  logic [SW-1:0]            gsq, wsq;
  logic [CW-1:0]            gcnt;
  logic signed [VALUE_BITS-1:0] glo, ghi;
  logic [63:0]              glob;
  logic [15:0]              lcnt;
  logic [15:0]              tag;

  logic [2*VALUE_BITS-1:0]  sq;
  logic [SW:0]              wsum;
  assign sq   = (2*VALUE_BITS)'($signed(value) * $signed(value));
  assign wsum = {1'b0, wsq} + (SW+1)'(sq);

  // iterative engines: 64-bit sqrt two bits per cycle, 64-bit divide one bit per cycle
  logic [63:0] sx, sres, sbit;
  logic        sbusy;
  logic [63:0] dq, drem, dden;
  logic [6:0]  dstep;
  logic        dbusy;
  logic        dneg;
  logic [63:0] r_gn, r_wn, r_vr;
  logic signed [63:0] r_mean;
  logic [63:0] r_dev, r_ratio;
  gns_pkg::sel_t opsel;

  logic [63:0] vx, sabs;
  assign sabs = gsum < 0 ? 64'(-gsum) : 64'(gsum);

  // variance numerator built in halves while the two norm roots run
  logic [63:0] gsq64, p_lo, p_hi, ssq;
  logic [31:0] n32, sabs_r;
  assign gsq64 = 64'(gsq);
  assign n32   = 32'(gcnt);
  assign p_lo  = 64'(n32) * 64'(gsq64[31:0]);
  assign p_hi  = 64'(n32) * 64'(gsq64[63:32]);

  logic [63:0] sq_in, d_num, d_den;
  always_comb begin
    unique case (cmd.sel)
      gns_pkg::SEL_WNORM: sq_in = 64'(wsq);
      gns_pkg::SEL_VAR:   sq_in = vx - ssq;
      gns_pkg::SEL_GLOB:  sq_in = glob;
      default:            sq_in = 64'(gsq);
    endcase
    unique case (cmd.sel)
      gns_pkg::SEL_DEV:   begin d_num = r_vr;  d_den = 64'(gcnt); end
      gns_pkg::SEL_RATIO: begin d_num = r_gn << 16; d_den = r_wn; end
      default:            begin d_num = sabs; d_den = 64'(gcnt); end
    endcase
  end

  logic [63:0] s_try;
  logic [64:0] d_sh;
  assign s_try = sres + sbit;
  assign d_sh  = {drem, dq[63]};

  assign stat.op_done    = !sbusy && !dbusy;
  assign stat.have_grad  = gcnt != '0;
  assign stat.wnorm_zero = r_wn == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      gsum <= '0; gsq <= '0; wsq <= '0; gcnt <= '0;
      glo <= {1'b0, {(VALUE_BITS-1){1'b1}}};
      ghi <= {1'b1, {(VALUE_BITS-1){1'b0}}};
      glob <= '0; lcnt <= '0;
      sbusy <= 1'b0; dbusy <= 1'b0;
    end else begin
      strobe <= cmd.emit_layer || cmd.emit_flush;
      if (cmd.accept) begin
        tag <= layer_index;
        if (action == gns_pkg::ACT_GRAD && gcnt < MAXN) begin
          gsum <= gsum + GW'(value);
          gsq  <= gsq + SW'(sq);
          gcnt <= gcnt + 1'b1;
          if (value < glo) glo <= value;
          if (value > ghi) ghi <= value;
        end else if (action == gns_pkg::ACT_WEIGHT) begin
          wsq <= (wsum > (SW+1)'(WSQ_LIMIT)) ? WSQ_LIMIT : wsum[SW-1:0];
        end
      end
      if (cmd.start_op) begin
        opsel <= cmd.sel;
        // low half of count times square sum, then the high half and the squared sum
        if (cmd.sel == gns_pkg::SEL_GNORM) begin
          vx <= p_lo;
          sabs_r <= sabs[31:0];
        end
        if (cmd.sel == gns_pkg::SEL_WNORM) begin
          vx <= vx + {p_hi[31:0], 32'd0};
          ssq <= 64'(sabs_r) * 64'(sabs_r);
        end
        if (cmd.op == gns_pkg::OP_SQRT) begin
          sbusy <= 1'b1;
          sx <= sq_in;
          sres <= '0;
          sbit <= 64'h4000_0000_0000_0000;
        end else begin
          dbusy <= 1'b1;
          dq <= d_num; drem <= '0; dden <= d_den; dstep <= '0;
          dneg <= (cmd.sel == gns_pkg::SEL_MEAN) && gsum < 0;
        end
      end
      if (sbusy) begin
        if (sbit == '0) begin
          sbusy <= 1'b0;
          unique case (opsel)
            gns_pkg::SEL_WNORM: r_wn <= sres;
            gns_pkg::SEL_VAR:   r_vr <= sres;
            default:            r_gn <= sres;
          endcase
        end else begin
          if (sx >= s_try) begin
            sx <= sx - s_try;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
        end
      end
      if (dbusy) begin
        if (dstep == 7'd64) begin
          dbusy <= 1'b0;
          unique case (opsel)
            gns_pkg::SEL_MEAN: r_mean <= dneg ? -$signed(dq) : $signed(dq);
            gns_pkg::SEL_DEV:  r_dev <= dq;
            default:           r_ratio <= dq;
          endcase
        end else begin
          dstep <= dstep + 1'b1;
          if (d_sh >= {1'b0, dden}) begin
            drem <= 64'(d_sh - {1'b0, dden});
            dq <= {dq[62:0], 1'b1};
          end else begin
            drem <= d_sh[63:0];
            dq <= {dq[62:0], 1'b0};
          end
        end
      end
      if (cmd.emit_layer) begin
        kind <= 1'b0;
        layer_tag <= tag;
        count <= 17'(gcnt);
        if (gcnt != '0) begin
          mean <= 16'(r_mean); deviation <= 16'(r_dev);
          minimum <= 16'(glo); maximum <= 16'(ghi);
          grad_norm <= 32'(r_gn);
        end else begin
          mean <= '0; deviation <= '0; minimum <= '0; maximum <= '0;
          grad_norm <= '0;
        end
        weight_norm <= 24'(r_wn);
        ratio <= (r_wn == '0) ? '0 : (r_ratio[63:32] != '0) ? '1 : r_ratio[31:0];
        glob <= (glob > ~64'(gsq)) ? '1 : glob + 64'(gsq);
        if (lcnt != 16'hFFFF) lcnt <= lcnt + 1'b1;
        gsum <= '0; gsq <= '0; wsq <= '0; gcnt <= '0;
        glo <= {1'b0, {(VALUE_BITS-1){1'b1}}};
        ghi <= {1'b1, {(VALUE_BITS-1){1'b0}}};
      end
      if (cmd.emit_flush) begin
        kind <= 1'b1; layer_tag <= '0; count <= 17'(lcnt);
        mean <= '0; deviation <= '0; minimum <= '0; maximum <= '0;
        grad_norm <= 32'(r_gn); weight_norm <= '0; ratio <= '0;
      end
      if (cmd.flush) begin
        glob <= '0; lcnt <= '0;
      end
    end
  end

  `GNS_ASSERT_ALWAYS(a_one_engine, clk, rst, !(sbusy && dbusy))
  `GNS_ASSERT_ALWAYS(a_count_max, clk, rst, gcnt <= MAXN)
  `GNS_ASSERT_ALWAYS(a_wsq_max, clk, rst, wsq <= WSQ_LIMIT)
endmodule
`default_nettype wire

### verif/gradient_norm_statistics_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// layer statistics testbench: gradient, weight and flush beats go in through the start/busy
// handshake, every strobed summary is compared with a model kept here or a hand-written row
module gradient_norm_statistics_tb;
  // action code that the block must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam longint unsigned WEIGHT_SQ_LIMIT = 64'd65536 << 30;

  // one summary as it leaves the block
  typedef struct packed {
    logic               kind;
    logic [15:0]        tag;
    logic [16:0]        cnt;
    logic signed [15:0] avg;
    logic [15:0]        dev;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic [31:0]        gnorm;
    logic [23:0]        wnorm;
    logic [31:0]        rat;
  } summary_t;

  // directed stimulus; typed rows carry the summary written out by hand
  typedef struct packed {
    logic [1:0]         act;
    logic signed [15:0] val;
    logic               lst;
    logic [15:0]        id;
    logic               typed;
    summary_t           res;
  } beat_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] action = gns_pkg::ACT_GRAD;
  logic signed [15:0] value = '0;
  logic last = 1'b0;
  logic [15:0] layer_index = '0;
  logic busy, strobe, kind;
  logic [15:0] layer_tag, deviation;
  logic [16:0] count;
  logic signed [15:0] mean, minimum, maximum;
  logic [31:0] grad_norm, ratio;
  logic [23:0] weight_norm;

  gradient_norm_statistics dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .value(value),
    .last(last), .layer_index(layer_index), .strobe(strobe), .kind(kind),
    .layer_tag(layer_tag),
    .count(count), .mean(mean), .deviation(deviation), .minimum(minimum),
    .maximum(maximum), .grad_norm(grad_norm), .weight_norm(weight_norm), .ratio(ratio)
  );

  always #2 clk = ~clk;

  // model state: per-layer sums and the batch totals
  longint             layer_sum;
  longint unsigned    layer_sq, weight_sq, batch_sq;
  int unsigned        layer_elems, batch_layers;
  logic signed [15:0] layer_lo, layer_hi;

  summary_t pending_summaries[$];
  beat_row_t directed[$];
  int mismatches = 0;
  int gap_pct = 0;
  int beats_sent = 0;
  int gap_pct_list[3] = '{18, 55, 0};

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= root + b) begin
        x = x - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  task automatic clear_layer_stats();
    layer_sum = 0;
    layer_sq = 0;
    weight_sq = 0;
    layer_elems = 0;
    layer_lo = 16'sh7fff;
    layer_hi = -16'sh8000;
  endtask

  // advance the model by one accepted beat; returns 1 with a summary where one is due
  task automatic model_beat(input logic [1:0] act, input logic signed [15:0] val,
                            input logic lst, input logic [15:0] id,
                            output bit has_res, output summary_t res);
    longint v, avg;
    longint unsigned sq, n, gn, wn, rt, s_abs;
    v = val;
    sq = longint'(v * v);
    has_res = 0;
    res = '0;
    case (act)
      gns_pkg::ACT_GRAD: begin
        // elements past the capacity are dropped silently
        if (layer_elems < gns_pkg::MaxElements) begin
          layer_sum += v;
          layer_sq += sq;
          layer_elems++;
          if (val < layer_lo) layer_lo = val;
          if (val > layer_hi) layer_hi = val;
        end
      end
      gns_pkg::ACT_FLUSH: begin
        has_res = 1;
        res.kind = 1'b1;
        res.cnt = batch_layers[16:0];
        res.gnorm = 32'(floor_sqrt(batch_sq));
        batch_sq = 0;
        batch_layers = 0;
      end
      gns_pkg::ACT_WEIGHT: begin
        if (weight_sq + sq > WEIGHT_SQ_LIMIT) weight_sq = WEIGHT_SQ_LIMIT;
        else weight_sq += sq;
        if (lst) begin
          has_res = 1;
          n = layer_elems;
          gn = floor_sqrt(layer_sq);
          wn = floor_sqrt(weight_sq);
          res.tag = id;
          res.cnt = n[16:0];
          res.gnorm = gn[31:0];
          res.wnorm = wn[23:0];
          // empty gradient leaves the statistics at zero
          if (n != 0) begin
            s_abs = layer_sum < 0 ? -layer_sum : layer_sum;
            avg = layer_sum / longint'(n);
            res.avg = avg[15:0];
            res.dev = 16'(floor_sqrt(n * layer_sq - s_abs * s_abs) / n);
            res.lo = layer_lo;
            res.hi = layer_hi;
          end
          // zero weight norm gives a zero ratio, otherwise saturating
          if (wn != 0) begin
            rt = (gn << 16) / wn;
            res.rat = rt > 64'hffff_ffff ? 32'hffff_ffff : rt[31:0];
          end
          if (batch_sq > 64'hffff_ffff_ffff_ffff - layer_sq) batch_sq = '1;
          else batch_sq += layer_sq;
          if (batch_layers < 65535) batch_layers++;
          clear_layer_stats();
        end
      end
      default: ;  // unused action code
    endcase
  endtask

  // one beat through the handshake, with random idle cycles first
  task automatic send_beat(input logic [1:0] act, input logic signed [15:0] val,
                           input logic lst, input logic [15:0] id,
                           input bit typed, input summary_t typed_res);
    bit has_res;
    summary_t res;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    value <= val;
    last <= lst;
    layer_index <= id;
    // busy read here is its value at the edge just taken
    do @(posedge clk); while (busy);
    model_beat(act, val, lst, id, has_res, res);
    beats_sent++;
    if (has_res)
      pending_summaries.insert(pending_summaries.size(), typed ? typed_res : res);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return $signed(16'($urandom_range(0, 64))) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", name, exp_v, act_v);
    end
  endfunction

  // outputs sampled at the edge that ends the strobe cycle
  always @(posedge clk) begin
    summary_t exp_s;
    if (!rst && strobe) begin
      if (pending_summaries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("summary beat with nothing expected");
      end else begin
        exp_s = pending_summaries.pop_front();
        check_field("kind", 32'(exp_s.kind), 32'(kind));
        check_field("layer_tag", 32'(exp_s.tag), 32'(layer_tag));
        check_field("count", 32'(exp_s.cnt), 32'(count));
        check_field("mean", 32'(16'(exp_s.avg)), 32'(16'(mean)));
        check_field("deviation", 32'(exp_s.dev), 32'(deviation));
        check_field("minimum", 32'(16'(exp_s.lo)), 32'(16'(minimum)));
        check_field("maximum", 32'(16'(exp_s.hi)), 32'(16'(maximum)));
        check_field("grad_norm", exp_s.gnorm, grad_norm);
        check_field("weight_norm", 32'(exp_s.wnorm), 32'(weight_norm));
        check_field("ratio", exp_s.rat, ratio);
      end
    end
  end

  task automatic add_row(input logic [1:0] act, input logic signed [15:0] val,
                         input logic lst, input logic [15:0] id,
                         input logic typed, input summary_t res);
    beat_row_t row;
    row = '{act, val, lst, id, typed, res};
    directed.insert(directed.size(), row);
  endtask

  // one layer of random length and content, sometimes broken by strays
  task automatic random_layer();
    int n_grad, n_wt;
    n_grad = $urandom_range(9) == 0 ? $urandom_range(20, 40) : $urandom_range(0, 10);
    n_wt = $urandom_range(0, 5);
    repeat (n_grad)
      send_beat(gns_pkg::ACT_GRAD, pick_value(), 1'($urandom), 16'($urandom), 0, '0);
    repeat (n_wt) begin
      // occasional noise between weight beats
      if ($urandom_range(15) == 0)
        send_beat(ACT_UNUSED, pick_value(), 1'($urandom), 16'($urandom), 0, '0);
      send_beat(gns_pkg::ACT_WEIGHT, pick_value(), 1'b0, 16'($urandom), 0, '0);
    end
    send_beat(gns_pkg::ACT_WEIGHT, pick_value(), 1'b1, 16'($urandom), 0, '0);
    if ($urandom_range(5) == 0) send_beat(gns_pkg::ACT_FLUSH, pick_value(), 1'($urandom),
                                          16'($urandom), 0, '0);
  endtask

  initial begin
    int stop_at;
    clear_layer_stats();
    batch_sq = 0;
    batch_layers = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // flush straight after reset, then a layer with no gradients
    add_row(gns_pkg::ACT_FLUSH, 16'sd0, 1'b0, 16'h0000, 1'b1,
            '{1'b1, 16'd0, 17'd0, 16'sd0, 16'd0, 16'sd0, 16'sd0, 32'd0, 24'd0, 32'd0});
    add_row(gns_pkg::ACT_WEIGHT, 16'sd0, 1'b1, 16'h0005, 1'b1,
            '{1'b0, 16'd5, 17'd0, 16'sd0, 16'd0, 16'sd0, 16'sd0, 32'd0, 24'd0, 32'd0});
    // single extreme gradient against the most negative weight
    add_row(gns_pkg::ACT_GRAD, 16'sh7fff, 1'b0, 16'h0000, 1'b0, '0);
    add_row(gns_pkg::ACT_WEIGHT, -16'sh8000, 1'b1, 16'hffff, 1'b1,
            '{1'b0, 16'hffff, 17'd1, 16'sh7fff, 16'd0, 16'sh7fff, 16'sh7fff,
              32'd32767, 24'd32768, 32'd65534});
    // gradient last flag does nothing; unused action dropped mid layer
    add_row(gns_pkg::ACT_GRAD, -16'sh8000, 1'b1, 16'h0000, 1'b0, '0);
    add_row(gns_pkg::ACT_GRAD, 16'sd0, 1'b0, 16'h0000, 1'b0, '0);
    add_row(gns_pkg::ACT_GRAD, 16'sd1, 1'b0, 16'h0000, 1'b0, '0);
    add_row(ACT_UNUSED, -16'sd1, 1'b1, 16'hffff, 1'b0, '0);
    add_row(gns_pkg::ACT_WEIGHT, 16'sd1, 1'b0, 16'h0000, 1'b0, '0);
    add_row(gns_pkg::ACT_WEIGHT, 16'sd0, 1'b1, 16'h1234, 1'b0, '0);
    add_row(gns_pkg::ACT_FLUSH, 16'sd0, 1'b0, 16'h0000, 1'b0, '0);
    // second flush finds the totals already cleared
    add_row(gns_pkg::ACT_FLUSH, -16'sd1, 1'b1, 16'hffff, 1'b1,
            '{1'b1, 16'd0, 17'd0, 16'sd0, 16'd0, 16'sd0, 16'sd0, 32'd0, 24'd0, 32'd0});
    add_row(gns_pkg::ACT_GRAD, -16'sd1, 1'b0, 16'h0000, 1'b0, '0);
    add_row(gns_pkg::ACT_WEIGHT, 16'sh7fff, 1'b1, 16'h8000, 1'b0, '0);
    // four extreme gradients over a tiny weight norm saturate the ratio
    repeat (4) add_row(gns_pkg::ACT_GRAD, -16'sh8000, 1'b0, 16'h0000, 1'b0, '0);
    add_row(gns_pkg::ACT_WEIGHT, 16'sd1, 1'b1, 16'h00ff, 1'b0, '0);
    add_row(gns_pkg::ACT_FLUSH, 16'sd0, 1'b0, 16'h0000, 1'b0, '0);

    foreach (directed[i])
      send_beat(directed[i].act, directed[i].val, directed[i].lst, directed[i].id,
                directed[i].typed, directed[i].res);
    // sender holds off until every summary is back
    drain();

    // random layers: before each beat the sender keeps idling with 18 then 55 percent odds, then not at all
    foreach (gap_pct_list[p]) begin
      gap_pct = gap_pct_list[p];
      stop_at = beats_sent + 190;
      while (beats_sent < stop_at) random_layer();
      drain();
    end
    gap_pct = 0;

    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending_summaries.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

### gradient_norm_statistics.f
+incdir+src
src/gns_pkg.sv
src/gns_ctrl.sv
src/gns_dp.sv
src/gradient_norm_statistics.sv
verif/gradient_norm_statistics_tb.sv
